[rtl/nbrs_pkg.sv]
// shared types and constants for the numbered bucket record store
// no dependencies
package nbrs_pkg;

  localparam int unsigned NUM_BUCKETS_DEF = 64;
  localparam int unsigned MAX_WORDS_DEF   = 32;
  localparam int unsigned LEN_W           = 7;
  localparam int unsigned CFG_W           = 7;
  localparam logic [CFG_W-1:0] CFG_RESET  = 7'd64;
  localparam int unsigned CMD_DEPTH       = 2;
  localparam int unsigned OUT_DEPTH       = 4;

  typedef enum logic [1:0] {
    MODE_PUT_HDR = 2'd0,
    MODE_PUT_VAL = 2'd1,
    MODE_OUTPUT  = 2'd2,
    MODE_EMPTY   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_VALUE     = 3'd0,
    ST_NOT_EMPTY = 3'd1,
    ST_NO_BUCKET = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_TOO_LONG  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CMD_RESULT = 2'd0,
    CMD_SETLEN = 2'd1,
    CMD_WRITE  = 2'd2,
    CMD_READ   = 2'd3
  } cmd_kind_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_LEN,
    B_NONE,
    B_ADDR,
    B_DATA
  } back_state_e;

  // work handed from the front to the back
  typedef struct packed {
    cmd_kind_e        kind;
    status_e          status;
    logic [7:0]       echo;
    logic [7:0]       bucket;
    logic [LEN_W-1:0] pos;
    logic [31:0]      value;
  } cmd_t;

  // one result transaction
  typedef struct packed {
    status_e     status;
    logic [7:0]  echo;
    logic [31:0] value;
    logic        last;
    logic        none;
  } result_t;

endpackage

[rtl/nbrs_fifo.sv]
// small register queue used for commands and results
// no package dependencies
module nbrs_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, rptr_q;
  logic [CW-1:0]    cnt_q;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

[rtl/nbrs_front.sv]
// front end: takes items, checks buckets, tracks put runs, issues commands
// depends on nbrs_pkg
module nbrs_front #(
  parameter int unsigned NUM_BUCKETS = nbrs_pkg::NUM_BUCKETS_DEF,
  parameter int unsigned MAX_WORDS   = nbrs_pkg::MAX_WORDS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  input  logic [nbrs_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                      accept_i,
  input  logic [1:0]                mode_i,
  input  logic [7:0]                bucket_number_i,
  input  logic [7:0]                word_count_i,
  input  logic [31:0]               word_value_i,
  output logic                      cmd_push_o,
  output nbrs_pkg::cmd_t            cmd_o
);
  import nbrs_pkg::*;

  localparam int unsigned BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;

  logic [CFG_W-1:0]       cfg_q;
  logic [NUM_BUCKETS-1:0] flags_q, flags_d;
  logic [7:0]             pend_q, pend_d;
  logic [BW-1:0]          target_q, target_d;
  logic                   discard_q, discard_d;
  logic [LEN_W-1:0]       wpos_q, wpos_d;

  logic [8:0] limit;
  logic       valid_b;
  logic [7:0] idx_full;
  logic [BW-1:0] idx;
  logic       filled;
  mode_e      mode;

  // bucket range check against the configured count
  assign limit = (9'(cfg_q) > 9'(NUM_BUCKETS)) ? 9'(NUM_BUCKETS) : 9'(cfg_q);
  assign valid_b  = (bucket_number_i != 8'd0) && (9'(bucket_number_i) <= limit);
  assign idx_full = bucket_number_i - 8'd1;
  assign idx      = idx_full[BW-1:0];
  assign filled   = flags_q[idx];
  assign mode     = mode_e'(mode_i);

  // classify the item
  always_comb begin
    flags_d    = flags_q;
    pend_d     = pend_q;
    target_d   = target_q;
    discard_d  = discard_q;
    wpos_d     = wpos_q;
    cmd_push_o = 1'b0;
    cmd_o      = '{kind: CMD_RESULT, status: ST_VALUE, echo: bucket_number_i,
                   bucket: idx_full, pos: '0, value: word_value_i};
    if (accept_i) begin
      unique case (mode)
        MODE_PUT_HDR: begin
          pend_d = word_count_i;
          wpos_d = '0;
          if (valid_b && !filled && (word_count_i <= 8'(MAX_WORDS))) begin
            flags_d[idx] = 1'b1;
            target_d     = idx;
            discard_d    = 1'b0;
            cmd_push_o   = 1'b1;
            cmd_o.kind   = CMD_SETLEN;
            cmd_o.pos    = word_count_i[LEN_W-1:0];
          end else begin
            discard_d    = (word_count_i != 8'd0);
            cmd_push_o   = 1'b1;
            cmd_o.status = !valid_b ? ST_NO_BUCKET : (filled ? ST_NOT_EMPTY : ST_TOO_LONG);
          end
        end
        MODE_PUT_VAL: begin
          if (pend_q != 8'd0) begin
            pend_d = pend_q - 8'd1;
            if (!discard_q && (wpos_q < LEN_W'(MAX_WORDS))) begin
              cmd_push_o   = 1'b1;
              cmd_o.kind   = CMD_WRITE;
              cmd_o.bucket = 8'(target_q);
              cmd_o.pos    = wpos_q;
              wpos_d       = wpos_q + 1'b1;
            end
            if (pend_q == 8'd1) begin
              discard_d = 1'b0;
            end
          end
        end
        MODE_OUTPUT: begin
          cmd_push_o = 1'b1;
          if (!valid_b) begin
            cmd_o.status = ST_NO_BUCKET;
          end else if (!filled) begin
            cmd_o.status = ST_EMPTY;
          end else begin
            cmd_o.kind = CMD_READ;
          end
        end
        MODE_EMPTY: begin
          if (!valid_b) begin
            cmd_push_o   = 1'b1;
            cmd_o.status = ST_NO_BUCKET;
          end else begin
            flags_d[idx] = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // front state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q     <= CFG_RESET;
      flags_q   <= '0;
      pend_q    <= '0;
      target_q  <= '0;
      discard_q <= 1'b0;
      wpos_q    <= '0;
    end else begin
      if (cfg_valid_i) begin
        cfg_q <= cfg_data_i;
      end
      flags_q   <= flags_d;
      pend_q    <= pend_d;
      target_q  <= target_d;
      discard_q <= discard_d;
      wpos_q    <= wpos_d;
    end
  end

endmodule

[rtl/nbrs_back.sv]
// back end: owns the length and word memories, runs commands, emits results
// depends on nbrs_pkg
module nbrs_back #(
  parameter int unsigned NUM_BUCKETS = nbrs_pkg::NUM_BUCKETS_DEF,
  parameter int unsigned MAX_WORDS   = nbrs_pkg::MAX_WORDS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_empty_i,
  input  nbrs_pkg::cmd_t    cmd_i,
  output logic              cmd_pop_o,
  input  logic              out_full_i,
  output logic              out_push_o,
  output nbrs_pkg::result_t out_o
);
  import nbrs_pkg::*;

  localparam int unsigned BW    = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int unsigned DEPTH = NUM_BUCKETS * MAX_WORDS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [31:0]      word_mem [DEPTH];
  logic [LEN_W-1:0] len_mem  [NUM_BUCKETS];
  logic [31:0]      word_rd_q;
  logic [LEN_W-1:0] len_rd_q;

  back_state_e      state_q, state_d;
  logic [BW-1:0]    bkt_q;
  logic [7:0]       echo_q;
  logic [LEN_W-1:0] len_q, pos_q;

  logic             word_we, word_re, len_we, len_re;
  logic [AW-1:0]    word_waddr, word_raddr;
  logic [BW-1:0]    cmd_bkt;
  logic             last_word;

  assign cmd_bkt    = cmd_i.bucket[BW-1:0];
  assign word_waddr = AW'(AW'(cmd_bkt) * AW'(MAX_WORDS)) + AW'(cmd_i.pos);
  assign word_raddr = AW'(AW'(bkt_q) * AW'(MAX_WORDS)) + AW'(pos_q);
  assign last_word  = (pos_q + 1'b1 == len_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: begin
        if (!cmd_empty_i && cmd_i.kind == CMD_READ) begin
          state_d = B_LEN;
        end
      end
      B_LEN:  state_d = (len_rd_q == '0) ? B_NONE : B_ADDR;
      B_NONE: if (!out_full_i) state_d = B_IDLE;
      B_ADDR: if (!out_full_i) state_d = B_DATA;
      B_DATA: state_d = last_word ? B_IDLE : B_ADDR;
      default: state_d = B_IDLE;
    endcase
  end

  // command handshakes, memory strobes and result fields
  always_comb begin
    cmd_pop_o  = 1'b0;
    out_push_o = 1'b0;
    word_we    = 1'b0;
    word_re    = 1'b0;
    len_we     = 1'b0;
    len_re     = 1'b0;
    out_o      = '{status: ST_VALUE, echo: echo_q, value: 32'd0, last: 1'b1, none: 1'b0};
    unique case (state_q)
      B_IDLE: begin
        if (!cmd_empty_i) begin
          case (cmd_i.kind)
            CMD_RESULT: begin
              out_o.status = cmd_i.status;
              out_o.echo   = cmd_i.echo;
              if (!out_full_i) begin
                cmd_pop_o  = 1'b1;
                out_push_o = 1'b1;
              end
            end
            CMD_SETLEN: begin
              cmd_pop_o = 1'b1;
              len_we    = 1'b1;
            end
            CMD_WRITE: begin
              cmd_pop_o = 1'b1;
              word_we   = 1'b1;
            end
            default: begin
              cmd_pop_o = 1'b1;
              len_re    = 1'b1;
            end
          endcase
        end
      end
      B_NONE: begin
        out_o.none = 1'b1;
        out_push_o = !out_full_i;
      end
      B_ADDR: word_re = !out_full_i;
      B_DATA: begin
        out_o.value = word_rd_q;
        out_o.last  = last_word;
        out_push_o  = 1'b1;
      end
      default: ;
    endcase
  end

  // walk state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // walk context
  always_ff @(posedge clk_i) begin
    if (len_re) begin
      bkt_q  <= cmd_bkt;
      echo_q <= cmd_i.echo;
    end
    if (state_q == B_LEN) begin
      len_q <= len_rd_q;
      pos_q <= '0;
    end else if (state_q == B_DATA) begin
      pos_q <= pos_q + 1'b1;
    end
  end

  // length memory
  always_ff @(posedge clk_i) begin
    if (len_we) begin
      len_mem[cmd_bkt] <= cmd_i.pos;
    end
    if (len_re) begin
      len_rd_q <= len_mem[cmd_bkt];
    end
  end

  // word memory
  always_ff @(posedge clk_i) begin
    if (word_we) begin
      word_mem[word_waddr] <= cmd_i.value;
    end
    if (word_re) begin
      word_rd_q <= word_mem[word_raddr];
    end
  end

endmodule

[rtl/numbered_bucket_record_store.sv]
// Numbered bucket record store: a front end that checks items and a back
// end that owns the bucket memories, joined by a command queue.
// Usage:
//   Items enter on push/full; an item is taken when push is high and full
//   low. Results leave on empty/pop, oldest first, taken when pop is high
//   and empty low. The bucket count register is written over cfg_valid_i /
//   cfg_ready_o (always ready); the user must write it only while the block
//   is idle, as the block itself does not enforce this.
//   Timing: the front takes one item a cycle while the two-entry command
//   queue has room. The back handles a put value, a header or an error
//   result in its idle state; an output item goes through a length read,
//   then per stored word a read state and a result state (one result with
//   an empty list) on the single read port of the word memory. Results
//   pass a four-entry queue.
//   Reset: all buckets unfilled, no put run pending, count register 64;
//   memories need no clearing pass and the block takes items at once.
//   A stalled receiver fills the result queue; the back then waits and the
//   command queue, then full, holds off new items.
module numbered_bucket_record_store #(
  parameter int unsigned NUM_BUCKETS = nbrs_pkg::NUM_BUCKETS_DEF,
  parameter int unsigned MAX_WORDS   = nbrs_pkg::MAX_WORDS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [nbrs_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                       push,
  output logic                       full,
  input  logic [1:0]                 mode_i,
  input  logic [7:0]                 bucket_number_i,
  input  logic [7:0]                 word_count_i,
  input  logic signed [31:0]         word_value_i,
  output logic                       empty,
  input  logic                       pop,
  output logic [2:0]                 status_o,
  output logic [7:0]                 bucket_echo_o,
  output logic signed [31:0]         read_value_o,
  output logic                       last_of_run_o,
  output logic                       list_has_none_o
);
  import nbrs_pkg::*;

  cmd_t    cmd_in, cmd_out;
  result_t res_in, res_out;
  logic    cmd_push, cmd_pop, cmd_full, cmd_empty;
  logic    res_push, res_full, accept;

  assign cfg_ready_o = 1'b1;
  assign accept      = push && !cmd_full;
  assign full        = cmd_full;

  // item checks
  nbrs_front #(.NUM_BUCKETS(NUM_BUCKETS), .MAX_WORDS(MAX_WORDS)) u_front (
    .clk_i, .rst_ni,
    .cfg_valid_i,
    .cfg_data_i,
    .accept_i        (accept),
    .mode_i,
    .bucket_number_i,
    .word_count_i,
    .word_value_i    (32'(word_value_i)),
    .cmd_push_o      (cmd_push),
    .cmd_o           (cmd_in)
  );

  // command queue
  nbrs_fifo #(.WIDTH($bits(cmd_t)), .DEPTH(CMD_DEPTH)) u_cmd_q (
    .clk_i, .rst_ni,
    .push_i  (cmd_push),
    .wdata_i (cmd_in),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_out),
    .full_o  (cmd_full),
    .empty_o (cmd_empty)
  );

  // memories and result generation
  nbrs_back #(.NUM_BUCKETS(NUM_BUCKETS), .MAX_WORDS(MAX_WORDS)) u_back (
    .clk_i, .rst_ni,
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .out_full_i  (res_full),
    .out_push_o  (res_push),
    .out_o       (res_in)
  );

  // result queue
  nbrs_fifo #(.WIDTH($bits(result_t)), .DEPTH(OUT_DEPTH)) u_res_q (
    .clk_i, .rst_ni,
    .push_i  (res_push),
    .wdata_i (res_in),
    .pop_i   (pop && !empty),
    .rdata_o (res_out),
    .full_o  (res_full),
    .empty_o (empty)
  );

  assign status_o        = res_out.status;
  assign bucket_echo_o   = res_out.echo;
  assign read_value_o    = signed'(res_out.value);
  assign last_of_run_o   = res_out.last;
  assign list_has_none_o = res_out.none;

endmodule

[bench/numbered_bucket_record_store_tb.sv]
// testbench for the numbered bucket record store: directed and random items
// checked against a bucket predictor kept in step with accepted items
// depends on nbrs_pkg and numbered_bucket_record_store
`timescale 1ns / 1ps

module numbered_bucket_record_store_tb;
  import nbrs_pkg::*;

  localparam int NB = 64;
  localparam int MW = 32;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic push = 1'b0;
  logic full;
  logic [1:0] mode_i = MODE_PUT_VAL;
  logic [7:0] bucket_number_i = '0;
  logic [7:0] word_count_i = '0;
  logic signed [31:0] word_value_i = '0;
  logic empty;
  logic pop = 1'b0;
  logic [2:0] status_o;
  logic [7:0] bucket_echo_o;
  logic signed [31:0] read_value_o;
  logic last_of_run_o;
  logic list_has_none_o;

  numbered_bucket_record_store DUT (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .push, .full, .mode_i, .bucket_number_i, .word_count_i, .word_value_i,
    .empty, .pop, .status_o, .bucket_echo_o, .read_value_o,
    .last_of_run_o, .list_has_none_o
  );

  // predictor state of the bucket store
  logic [CFG_W-1:0] bucket_limit;
  bit               is_filled [NB];
  int unsigned      stored_len [NB];
  logic [31:0]      words [NB][MW];
  bit               word_known [NB][MW];
  int unsigned      values_left;
  int unsigned      put_bucket;
  bit               dropping;
  int unsigned      put_pos;

  result_t expected_results [$];
  int errors = 0;
  int cycles = 0;
  bit idle_en = 1'b1;
  bit hold_req = 1'b0;
  bit holding = 1'b0;
  int pop_gap = 0;

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // long receiver hold, counted here
  always @(posedge clk_i) begin
    if (hold_req && !holding) begin
      holding = 1'b1;
      repeat (300) @(posedge clk_i);
      holding = 1'b0;
      hold_req = 1'b0;
    end
  end

  // receiver: random pop bursts
  always @(posedge clk_i) begin
    if (!rst_ni || holding) begin
      pop <= 1'b0;
    end else if (pop_gap > 0) begin
      pop_gap--;
      pop <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      pop_gap = $urandom_range(0, 5);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && pop && !empty) begin
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transaction status %0d bucket %0d",
                                   status_o, bucket_echo_o);
      end else begin
        want = expected_results.pop_front();
        if (status_o !== want.status || bucket_echo_o !== want.echo ||
            read_value_o !== want.value || last_of_run_o !== want.last ||
            list_has_none_o !== want.none) begin
          errors++;
          if (errors <= 10)
            $display("mismatch exp st %0d bk %0d val %h last %b none %b, got %0d %0d %h %b %b",
                     want.status, want.echo, want.value, want.last, want.none,
                     status_o, bucket_echo_o, read_value_o, last_of_run_o, list_has_none_o);
        end
      end
    end
  end

  function automatic bit bucket_ok(int unsigned b);
    int unsigned lim;
    lim = (bucket_limit > NB) ? NB : bucket_limit;
    return b >= 1 && b <= lim;
  endfunction

  // true when an output of bucket b touches only written entries
  function automatic bit readable(int unsigned b);
    if (!bucket_ok(b) || !is_filled[b-1]) return 1'b1;
    for (int i = 0; i < stored_len[b-1]; i++)
      if (!word_known[b-1][i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void queue_result(status_e st, logic [7:0] b, logic [31:0] v,
                                       logic last, logic none);
    result_t r;
    r.status = st;
    r.echo = b;
    r.value = v;
    r.last = last;
    r.none = none;
    expected_results.push_back(r);
  endfunction

  // expected results of one accepted item
  function automatic void predict_bucket_op(mode_e m, logic [7:0] b, logic [7:0] cnt,
                                            logic [31:0] val);
    status_e st;
    case (m)
      MODE_PUT_HDR: begin
        if (!bucket_ok(b)) st = ST_NO_BUCKET;
        else if (is_filled[b-1]) st = ST_NOT_EMPTY;
        else if (cnt > MW) st = ST_TOO_LONG;
        else st = ST_VALUE;
        values_left = cnt;
        put_pos = 0;
        if (st == ST_VALUE) begin
          is_filled[b-1] = 1'b1;
          stored_len[b-1] = cnt;
          put_bucket = b - 1;
          dropping = 1'b0;
        end else begin
          dropping = cnt != 0;
          queue_result(st, b, '0, 1'b1, 1'b0);
        end
      end
      MODE_PUT_VAL: begin
        if (values_left != 0) begin
          values_left--;
          if (!dropping && put_pos < MW) begin
            words[put_bucket][put_pos] = val;
            word_known[put_bucket][put_pos] = 1'b1;
            put_pos++;
          end
          if (values_left == 0) dropping = 1'b0;
        end
      end
      MODE_OUTPUT: begin
        if (!bucket_ok(b)) queue_result(ST_NO_BUCKET, b, '0, 1'b1, 1'b0);
        else if (!is_filled[b-1]) queue_result(ST_EMPTY, b, '0, 1'b1, 1'b0);
        else if (stored_len[b-1] == 0) queue_result(ST_VALUE, b, '0, 1'b1, 1'b1);
        else
          for (int i = 0; i < stored_len[b-1]; i++)
            queue_result(ST_VALUE, b, words[b-1][i], i + 1 == stored_len[b-1], 1'b0);
      end
      default: begin
        if (!bucket_ok(b)) queue_result(ST_NO_BUCKET, b, '0, 1'b1, 1'b0);
        else is_filled[b-1] = 1'b0;
      end
    endcase
  endfunction

  // offer one item and wait for its transaction
  task automatic send_item(mode_e m, logic [7:0] b, logic [7:0] cnt, logic [31:0] val);
    mode_e mm;
    mm = m;
    if (mm == MODE_OUTPUT && !readable(b)) mm = MODE_PUT_HDR;
    if (idle_en && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    push <= 1'b1;
    mode_i <= mm;
    bucket_number_i <= b;
    word_count_i <= cnt;
    word_value_i <= val;
    do @(posedge clk_i); while (full);
    predict_bucket_op(mm, b, cnt, val);
  endtask

  // stop offering and let the block run dry
  task automatic drain();
    push <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_bucket_limit(logic [CFG_W-1:0] v);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    bucket_limit = v;
  endtask

  task automatic put_run(logic [7:0] b, int n, int sent);
    send_item(MODE_PUT_HDR, b, n[7:0], '0);
    for (int i = 0; i < sent; i++) send_item(MODE_PUT_VAL, '0, '0, $urandom());
  endtask

  task automatic test_directed();
    send_item(MODE_PUT_HDR, 8'd0, 8'd0, '0);
    send_item(MODE_PUT_HDR, 8'd65, 8'd3, '0);
    for (int i = 0; i < 3; i++) send_item(MODE_PUT_VAL, '0, '0, 32'hFFFF_FFFF);
    send_item(MODE_PUT_HDR, 8'd1, 8'd255, '0);
    send_item(MODE_PUT_HDR, 8'd1, 8'd0, '0);
    send_item(MODE_OUTPUT, 8'd1, '0, '0);
    send_item(MODE_PUT_HDR, 8'd1, 8'd2, '0);
    send_item(MODE_OUTPUT, 8'd2, '0, '0);
    send_item(MODE_PUT_VAL, '0, '0, 32'h1234_5678);
    send_item(MODE_PUT_HDR, 8'd3, 8'd3, '0);
    send_item(MODE_PUT_VAL, '0, '0, 32'h8000_0000);
    send_item(MODE_PUT_VAL, '0, '0, 32'h7FFF_FFFF);
    send_item(MODE_PUT_VAL, '0, '0, 32'h0000_0000);
    send_item(MODE_OUTPUT, 8'd3, '0, '0);
    send_item(MODE_EMPTY, 8'd1, '0, '0);
    send_item(MODE_EMPTY, 8'd1, '0, '0);
    send_item(MODE_EMPTY, 8'd0, '0, '0);
    send_item(MODE_OUTPUT, 8'd255, '0, '0);
    // a header replaces a pending run
    send_item(MODE_PUT_HDR, 8'd4, 8'd2, '0);
    send_item(MODE_PUT_VAL, '0, '0, 32'h0BAD_F00D);
    put_run(8'd5, 1, 1);
    send_item(MODE_OUTPUT, 8'd5, '0, '0);
  endtask

  task automatic test_bucket_limit();
    write_bucket_limit(7'd1);
    put_run(8'd2, 1, 1);
    send_item(MODE_OUTPUT, 8'd1, '0, '0);
    write_bucket_limit(7'd0);
    send_item(MODE_OUTPUT, 8'd1, '0, '0);
    send_item(MODE_EMPTY, 8'd1, '0, '0);
    write_bucket_limit(7'd127);
    put_run(8'd64, 32, 32);
    send_item(MODE_OUTPUT, 8'd64, '0, '0);
    send_item(MODE_OUTPUT, 8'd65, '0, '0);
    write_bucket_limit(7'd20);
    send_item(MODE_OUTPUT, 8'd21, '0, '0);
    write_bucket_limit(7'd64);
  endtask

  task automatic random_items(int n);
    int unsigned pick, cnt;
    logic [7:0] b;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      b = ($urandom_range(0, 9) == 0) ? 8'($urandom()) : 8'($urandom_range(1, 12));
      if (pick < 45) begin
        cnt = $urandom_range(0, 9) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 6);
        if (cnt > MW) put_run(b, cnt, $urandom_range(0, 3));
        else put_run(b, cnt, ($urandom_range(0, 9) == 0 && cnt > 0) ? cnt - 1 : cnt);
      end else if (pick < 75) begin
        send_item(MODE_OUTPUT, b, 8'($urandom()), $urandom());
      end else if (pick < 92) begin
        send_item(MODE_EMPTY, b, 8'($urandom()), $urandom());
      end else begin
        send_item(MODE_PUT_VAL, 8'($urandom()), 8'($urandom()), $urandom());
      end
    end
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int i = 1; i <= 3; i++) put_run(i[7:0] + 8'd40, 4, 4);
    for (int i = 0; i < 6; i++) send_item(MODE_OUTPUT, 8'(41 + (i % 3)), '0, '0);
    // sender waits for every result before going on
    push <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    send_item(MODE_OUTPUT, 8'd42, '0, '0);
  endtask

  initial begin
    bucket_limit = CFG_RESET;
    for (int i = 0; i < NB; i++) begin
      is_filled[i] = 1'b0;
      stored_len[i] = 0;
      for (int j = 0; j < MW; j++) word_known[i][j] = 1'b0;
    end
    values_left = 0;
    put_bucket = 0;
    dropping = 1'b0;
    put_pos = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_bucket_limit();
    random_items(8);
    test_backpressure();
    write_bucket_limit(CFG_W'($urandom_range(1, 64)));
    random_items(6);
    write_bucket_limit(7'd64);
    idle_en = 1'b0;
    random_items(4);
    drain();
    if (errors == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
